@@ rtl/risc_integer_execute_unit_assert.svh @@
// Assertion macros shared by the execute unit modules.
`ifndef RISC_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define RISC_INTEGER_EXECUTE_UNIT_ASSERT_SVH
// Implication checked every cycle outside reset.
`define RIEU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RIEU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ rtl/rieu_pkg.sv @@
// ----------------------------------------------------------------------------
// rieu_pkg
// Types and constants of the integer execute unit.
// ----------------------------------------------------------------------------
package rieu_pkg;

   typedef enum logic [4:0] {
      OP_ADD = 5'd0, OP_ADDI = 5'd1, OP_AND = 5'd2, OP_OR = 5'd3, OP_XOR = 5'd4,
      OP_SUB = 5'd5, OP_SLT = 5'd6, OP_SLL = 5'd7, OP_SRL = 5'd8, OP_ROTR = 5'd9,
      OP_LUI = 5'd10, OP_MULT = 5'd11, OP_DIV = 5'd12, OP_MFHI = 5'd13,
      OP_MFLO = 5'd14, OP_BEQ = 5'd15, OP_BNE = 5'd16, OP_BGTZ = 5'd17,
      OP_BLEZ = 5'd18, OP_J = 5'd19, OP_JAL = 5'd20, OP_JR = 5'd21,
      OP_LW = 5'd22, OP_SW = 5'd23
   } opcode_type;

   localparam logic [4:0] LINK_REGISTER = 5'd31;
   localparam logic [31:0] LINK_OFFSET = 32'd8;
   localparam int DIV_STEPS = 32;

   typedef struct packed {
      logic start;      // latch item, operands read
      logic execute;    // perform non-iterative work
      logic div_start;  // begin iterative divide
      logic div_step;   // one restoring step
      logic div_finish; // write quotient and remainder
   } cmd_type;

   typedef struct packed {
      logic is_div;
      logic div_last;
   } status_type;

   typedef struct packed {
      logic [4:0]  operation;
      logic [4:0]  source_a;
      logic [4:0]  source_b;
      logic [4:0]  destination;
      logic [4:0]  shift_amount;
      logic signed [15:0] immediate;
      logic [25:0] jump_target;
      logic [31:0] memory_base;
      logic [31:0] load_data;
   } request_type;

   typedef struct packed {
      logic [31:0] program_counter;
      logic        branch_taken;
      logic [31:0] memory_address;
      logic        memory_read;
      logic        memory_write;
      logic [31:0] store_data;
      logic        divide_by_zero;
   } response_type;

endpackage

@@ rtl/rieu_channel_if.sv @@
// ----------------------------------------------------------------------------
// rieu_req_if / rieu_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface rieu_req_if;
   logic valid;
   logic ready;
   rieu_pkg::request_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rieu_rsp_if;
   logic valid;
   logic ready;
   rieu_pkg::response_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/rieu_controller.sv @@
// ----------------------------------------------------------------------------
// rieu_controller
// Sequences accept, execute, divide iterations and result delivery.
// ----------------------------------------------------------------------------
`include "risc_integer_execute_unit_assert.svh"
module rieu_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  rieu_pkg::status_type status,
   output rieu_pkg::cmd_type cmd
);
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001, ST_EXEC = 5'b00010, ST_DIV = 5'b00100,
      ST_DFIN = 5'b01000, ST_OUT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   logic      out_done;

   assign out_done  = (state_ff == ST_OUT) && rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || out_done;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.start = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.is_div) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.execute = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_DFIN;
         end
         ST_DFIN: begin
            cmd.div_finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (accept) state_in = ST_EXEC;
            else if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   `RIEU_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `RIEU_ASSERT_IMP(a_no_accept_busy, clock, reset,
      (state_ff == ST_DIV) || (state_ff == ST_EXEC), !req_ready)
   `RIEU_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == ST_EXEC)
endmodule

@@ rtl/rieu_datapath.sv @@
// ----------------------------------------------------------------------------
// rieu_datapath
// Register file, HI/LO, counter, ALU, multiplier and serial divider.
// ----------------------------------------------------------------------------
`include "risc_integer_execute_unit_assert.svh"
module rieu_datapath #(
   parameter int NUM_REGISTERS = 32
) (
   input  logic clock,
   input  logic reset,
   input  rieu_pkg::cmd_type cmd,
   input  rieu_pkg::request_type req,
   output rieu_pkg::status_type status,
   output rieu_pkg::response_type rsp
);
   localparam int IW = $clog2(NUM_REGISTERS);
   localparam int CW = $clog2(rieu_pkg::DIV_STEPS);

   logic [31:0] regs_ff [NUM_REGISTERS];
   rieu_pkg::request_type item_ff;
   logic [31:0] a_ff, b_ff, hi_ff, lo_ff, pc_ff;
   logic [63:0] prod;
   logic [31:0] rem_ff, quo_ff, div_ff;
   logic [CW-1:0] cnt_ff;
   logic        na_ff, nb_ff;
   logic [32:0] trial;
   logic        wr_en;
   logic [IW-1:0] wr_idx;
   logic [31:0] wr_val, imm, sa, sb;
   logic [4:0]  sh;
   rieu_pkg::response_type rsp_ff, rsp_in;
   logic [31:0] pc_in, hi_in, lo_in;

   assign imm  = {{16{item_ff.immediate[15]}}, item_ff.immediate};
   assign sh   = item_ff.shift_amount;
   assign prod = $signed(a_ff) * $signed(b_ff);
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, div_ff};
   assign status.is_div = (item_ff.operation == rieu_pkg::OP_DIV) && (b_ff != 32'd0);
   assign status.div_last = (cnt_ff == CW'(rieu_pkg::DIV_STEPS - 1));
   assign sa = a_ff;
   assign sb = b_ff;
   assign rsp = rsp_ff;

   always_comb begin
      wr_en = 1'b0; wr_idx = item_ff.destination[IW-1:0]; wr_val = '0;
      pc_in = pc_ff; hi_in = hi_ff; lo_in = lo_ff;
      rsp_in = '0;
      case (item_ff.operation)
         rieu_pkg::OP_ADD:  begin wr_en = 1'b1; wr_val = sa + sb; end
         rieu_pkg::OP_ADDI: begin
            wr_en = 1'b1; wr_idx = item_ff.source_b[IW-1:0]; wr_val = sa + imm;
         end
         rieu_pkg::OP_AND:  begin wr_en = 1'b1; wr_val = sa & sb; end
         rieu_pkg::OP_OR:   begin wr_en = 1'b1; wr_val = sa | sb; end
         rieu_pkg::OP_XOR:  begin wr_en = 1'b1; wr_val = sa ^ sb; end
         rieu_pkg::OP_SUB:  begin wr_en = 1'b1; wr_val = sa - sb; end
         rieu_pkg::OP_SLT:  begin
            wr_en = 1'b1; wr_val = {31'd0, $signed(sa) < $signed(sb)};
         end
         rieu_pkg::OP_SLL:  begin wr_en = 1'b1; wr_val = sa << sh; end
         rieu_pkg::OP_SRL:  begin wr_en = 1'b1; wr_val = sa >> sh; end
         rieu_pkg::OP_ROTR: begin
            wr_en = 1'b1; wr_val = 32'(({sa, sa} >> sh));
         end
         rieu_pkg::OP_LUI:  begin
            wr_en = 1'b1; wr_idx = item_ff.source_b[IW-1:0];
            wr_val = {item_ff.immediate, 16'd0};
         end
         rieu_pkg::OP_MULT: begin hi_in = prod[63:32]; lo_in = prod[31:0]; end
         rieu_pkg::OP_DIV:  rsp_in.divide_by_zero = (sb == 32'd0);
         rieu_pkg::OP_MFHI: begin wr_en = 1'b1; wr_val = hi_ff; end
         rieu_pkg::OP_MFLO: begin wr_en = 1'b1; wr_val = lo_ff; end
         rieu_pkg::OP_BEQ:  if (sa == sb) begin
            pc_in = pc_ff + (imm << 2); rsp_in.branch_taken = 1'b1;
         end
         rieu_pkg::OP_BNE:  if (sa != sb) begin
            pc_in = pc_ff + (imm << 2); rsp_in.branch_taken = 1'b1;
         end
         rieu_pkg::OP_BGTZ: if ($signed(sa) > 0) begin
            pc_in = pc_ff + (imm << 2); rsp_in.branch_taken = 1'b1;
         end
         rieu_pkg::OP_BLEZ: if ($signed(sa) <= 0) begin
            pc_in = pc_ff + (imm << 2); rsp_in.branch_taken = 1'b1;
         end
         rieu_pkg::OP_J:    begin
            pc_in = {4'd0, item_ff.jump_target, 2'd0}; rsp_in.branch_taken = 1'b1;
         end
         rieu_pkg::OP_JAL:  begin
            wr_en = 1'b1; wr_idx = rieu_pkg::LINK_REGISTER[IW-1:0];
            wr_val = pc_ff + rieu_pkg::LINK_OFFSET;
            pc_in = {4'd0, item_ff.jump_target, 2'd0}; rsp_in.branch_taken = 1'b1;
         end
         rieu_pkg::OP_JR:   begin pc_in = sa; rsp_in.branch_taken = 1'b1; end
         rieu_pkg::OP_LW:   begin
            rsp_in.memory_address = item_ff.memory_base + imm;
            rsp_in.memory_read = 1'b1;
            wr_en = 1'b1; wr_idx = item_ff.source_b[IW-1:0]; wr_val = item_ff.load_data;
         end
         rieu_pkg::OP_SW:   begin
            rsp_in.memory_address = item_ff.memory_base + imm;
            rsp_in.memory_write = 1'b1; rsp_in.store_data = sb;
         end
         default: ;
      endcase
      rsp_in.program_counter = pc_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         item_ff <= req;
         a_ff <= (req.source_a[IW-1:0] == '0) ? '0 : regs_ff[req.source_a[IW-1:0]];
         b_ff <= (req.source_b[IW-1:0] == '0) ? '0 : regs_ff[req.source_b[IW-1:0]];
      end
      if (cmd.div_start) begin
         na_ff <= a_ff[31]; nb_ff <= b_ff[31];
         quo_ff <= a_ff[31] ? -a_ff : a_ff;
         div_ff <= b_ff[31] ? -b_ff : b_ff;
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         if (!trial[32]) rem_ff <= trial[31:0];
         else rem_ff <= {rem_ff[30:0], quo_ff[31]};
         quo_ff <= {quo_ff[30:0], !trial[32]};
      end
      // A finished divide reports only the counter, which rsp_in already holds.
      if (cmd.execute || cmd.div_finish) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGISTERS; i++) regs_ff[i] <= '0;
         hi_ff <= '0; lo_ff <= '0; pc_ff <= '0; cnt_ff <= '0;
      end else begin
         if (cmd.execute) begin
            pc_ff <= pc_in; hi_ff <= hi_in; lo_ff <= lo_in;
            if (wr_en && wr_idx != '0) regs_ff[wr_idx] <= wr_val;
         end
         if (cmd.div_start) cnt_ff <= '0;
         if (cmd.div_step) cnt_ff <= cnt_ff + 1'b1;
         if (cmd.div_finish) begin
            lo_ff <= (na_ff != nb_ff) ? -quo_ff : quo_ff;
            hi_ff <= na_ff ? -rem_ff : rem_ff;
         end
      end
   end

   `RIEU_ASSERT_IMP(a_r0_zero, clock, reset, 1'b1, regs_ff[0] == 32'd0)
   `RIEU_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1,
      $onehot0({cmd.execute, cmd.div_start, cmd.div_step, cmd.div_finish}))
   `RIEU_ASSERT_NEXT(a_pc_div, clock, reset, cmd.div_step, $stable(pc_ff))
endmodule

@@ rtl/risc_integer_execute_unit.sv @@
// ----------------------------------------------------------------------------
// risc_integer_execute_unit
// Executes one decoded 32-bit instruction per request word.
// ----------------------------------------------------------------------------
// Each request word is one decoded instruction run against a 32-entry register
// file, HI, LO and the program counter; each yields one response word. Most
// instructions pass from the execute state to the output state, where response
// valid rises; div with a nonzero divisor instead passes a setup in the execute
// state, 32 steps of the radix-2 restoring divider that retires one quotient bit
// per cycle, and a finish state that sign-corrects quotient and remainder. A new
// word is accepted in the cycle its predecessor's response is taken, and not
// before. The counter moves only on branches and jumps; register 0 always reads
// zero.
module risc_integer_execute_unit #(
   parameter int NUM_REGISTERS = 32
) (
   input logic clock,
   input logic reset,
   rieu_req_if.sink   req_channel,
   rieu_rsp_if.source rsp_channel
);
   rieu_pkg::cmd_type    cmd;
   rieu_pkg::status_type status;

   // Controller decides when the datapath latches, executes and iterates.
   rieu_controller u_ctrl (
      .clock, .reset,
      .req_valid(req_channel.valid), .req_ready(req_channel.ready),
      .rsp_valid(rsp_channel.valid), .rsp_ready(rsp_channel.ready),
      .status, .cmd
   );

   // Datapath holds all architectural state and the response register.
   rieu_datapath #(.NUM_REGISTERS(NUM_REGISTERS)) u_dp (
      .clock, .reset, .cmd,
      .req(req_channel.payload), .status, .rsp(rsp_channel.payload)
   );
endmodule
